@@ sv/shbr_pkg.sv @@
package shbr_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_NUMBER = 2'd2,
    REQ_TEXT   = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic [5:0]  width;
    logic        signed_read;
    logic [13:0] text_limit;
    logic        new_string;
    logic        nl_stop;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               at_end;
    logic               text_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAW,
    ST_SYM,
    ST_DONE
  } state_t;

  localparam int MaxCodeLen = 16;
  localparam logic [7:0] ByteNewline = 8'h0A;
  localparam logic [7:0] BytePercent = 8'd37;
  localparam logic [7:0] ByteDot     = 8'd46;

  // code bits lsb first under a leading marker one
  localparam logic [11:0] CODE_ROM [256] = '{
    12'h006, 12'h03B, 12'h0C8, 12'h0EC, 12'h1A1, 12'h111, 12'h090, 12'h07F,
    12'h035, 12'h0B4, 12'h0E9, 12'h08B, 12'h093, 12'h06D, 12'h139, 12'h2AC,
    12'h0A5, 12'h258, 12'h3F0, 12'h3F8, 12'h5DD, 12'h7F3, 12'h62B, 12'h723,
    12'h2F4, 12'h58D, 12'h4AB, 12'h763, 12'h5EB, 12'h143, 12'h24F, 12'h1D4,
    12'h077, 12'h4D3, 12'h244, 12'h6CD, 12'h7C5, 12'h7F9, 12'h70D, 12'h7CD,
    12'h294, 12'h5AC, 12'h433, 12'h414, 12'h671, 12'h6F0, 12'h3F4, 12'h178,
    12'h0A7, 12'h1C3, 12'h1EF, 12'h397, 12'h153, 12'h1B1, 12'h20D, 12'h361,
    12'h207, 12'h2F1, 12'h399, 12'h591, 12'h523, 12'h2BC, 12'h344, 12'h5F3,
    12'h1CF, 12'h0D0, 12'h0FC, 12'h084, 12'h121, 12'h151, 12'h280, 12'h270,
    12'h33D, 12'h463, 12'h6D7, 12'h771, 12'h39D, 12'h6AB, 12'h5C7, 12'h733,
    12'h32C, 12'h49D, 12'h56B, 12'h76B, 12'h5D3, 12'h571, 12'h5E3, 12'h633,
    12'h4D7, 12'h6CB, 12'h370, 12'h2A8, 12'h2C7, 12'h305, 12'h2EB, 12'h1D8,
    12'h2F3, 12'h13C, 12'h3AB, 12'h38F, 12'h297, 12'h0B0, 12'h141, 12'h34F,
    12'h05C, 12'h128, 12'h2BD, 12'h2C4, 12'h198, 12'h28F, 12'h10C, 12'h1B3,
    12'h185, 12'h18C, 12'h147, 12'h179, 12'h0D9, 12'h0C0, 12'h117, 12'h119,
    12'h14B, 12'h1E1, 12'h1A3, 12'h173, 12'h16F, 12'h0E8, 12'h088, 12'h0E5,
    12'h05F, 12'h0A9, 12'h0CC, 12'h0FD, 12'h10F, 12'h183, 12'h101, 12'h187,
    12'h167, 12'h1E7, 12'h157, 12'h174, 12'h3CB, 12'h3C4, 12'h281, 12'h24D,
    12'h331, 12'h563, 12'h380, 12'h7D7, 12'h42B, 12'h545, 12'h46B, 12'h43D,
    12'h72B, 12'h4F9, 12'h4E3, 12'h645, 12'h52B, 12'h431, 12'h7EB, 12'h5B9,
    12'h314, 12'h5F9, 12'h533, 12'h42C, 12'h6DD, 12'h5C1, 12'h71D, 12'h5D1,
    12'h338, 12'h461, 12'h6E3, 12'h745, 12'h66B, 12'h4CD, 12'h4CB, 12'h54D,
    12'h238, 12'h7C1, 12'h63D, 12'h7BC, 12'h4C5, 12'h7AC, 12'h7E3, 12'h699,
    12'h7D3, 12'h614, 12'h603, 12'h5BC, 12'h69D, 12'h781, 12'h663, 12'h48D,
    12'h154, 12'h303, 12'h15D, 12'h060, 12'h089, 12'h7C7, 12'h707, 12'h1B8,
    12'h3F1, 12'h62C, 12'h445, 12'h403, 12'h51D, 12'h5C5, 12'h74D, 12'h41D,
    12'h200, 12'h7B9, 12'h4DD, 12'h581, 12'h50D, 12'h4B9, 12'h5CD, 12'h794,
    12'h5BD, 12'h594, 12'h78D, 12'h558, 12'h7BD, 12'h4C1, 12'h7DD, 12'h4F8,
    12'h2D1, 12'h291, 12'h499, 12'h6F8, 12'h423, 12'h471, 12'h6D3, 12'h791,
    12'h0C9, 12'h631, 12'h507, 12'h661, 12'h623, 12'h118, 12'h605, 12'h6C1,
    12'h5D7, 12'h4F0, 12'h6C5, 12'h700, 12'h7D1, 12'h7A8, 12'h61D, 12'hD00,
    12'h405, 12'h758, 12'h6F9, 12'h5A8, 12'h6B9, 12'h68D, 12'h0AF, 12'h064
  };

  typedef struct packed {
    logic [255:0] hit;
    logic         deeper;
  } match_t;

  // compare a partial code of n bits against all table entries
  function automatic match_t code_match(input logic [15:0] acc, input logic [4:0] n);
    match_t m;
    logic [11:0] c;
    logic [11:0] mask;
    m = '0;
    mask = (n >= 5'd12) ? 12'hFFF : ((12'd1 << n) - 12'd1);
    for (int s = 0; s < 256; s++) begin
      c = CODE_ROM[s];
      if ((c & mask) == acc[11:0] && (n >= 5'd12 || acc[15:12] == 4'd0)) begin
        if (n < 5'd12 && c[n[3:0]] && ((c >> n) == 12'd1)) m.hit[s] = 1'b1;
        else if (n < 5'd12 && ((c >> n) > 12'd1)) m.deeper = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [8:0] top_hit(input logic [255:0] hit);
    logic [8:0] r;
    r = 9'h100;
    for (int s = 0; s < 256; s++) begin
      if (hit[s]) r = {1'b0, 8'(s)};
    end
    return r;
  endfunction

endpackage

@@ sv/shbr_front.sv @@
module shbr_front
  import shbr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     take,
  output logic     q_push,
  output in_item_t q_item
);

  // clear and append run in the back part too, keeping order with reads
  assign take   = start && !q_full;
  assign q_push = take;

  always_comb begin
    q_item = in_item;
    if (in_item.width > 6'd32) q_item.width = 6'd32;
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push into full queue");

endmodule

@@ sv/shbr_queue.sv @@
module shbr_queue
  import shbr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t push_item,
  input  logic     pop,
  output logic     full,
  output logic     valid,
  output in_item_t head
);

  in_item_t    mem_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !valid |-> !pop)
    else $error("queue underflow");

endmodule

@@ sv/shbr_back.sv @@
module shbr_back
  import shbr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384,
  parameter int MAX_TEXT     = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      res_valid,
  output out_item_t res
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int BW = CW + 3;
  localparam int TW = $clog2(MAX_TEXT + 1);

  logic [7:0] buf_mem [BUFFER_BYTES];
  logic [7:0] rd_byte_r;

  state_t      state_r, state_nxt;
  in_item_t    cur_r;
  logic [CW-1:0] count_r;
  logic [BW-1:0] cursor_r;
  logic [TW-1:0] chars_r;
  logic [2:0]  raw_left_r;
  logic [2:0]  raw_pos_r;
  logic [2:0]  bytes_left_r;
  logic [1:0]  byte_idx_r;
  logic [15:0] acc_r;
  logic [4:0]  n_r;
  logic [31:0] raw_r;
  logic [31:0] dec_r;
  logic        fetch_r;
  logic        fail_r;
  logic        tend_r;
  logic [31:0] tval_r;

  logic        done_w;
  logic [BW-1:0] bits_total;
  logic        bit_w;
  match_t      mt;
  logic [8:0]  hit_w;
  logic [TW-1:0] limit_w;
  logic [14:0] lim_in;
  logic        lim_hit_w;

  assign bits_total = {count_r, 3'b000};
  assign done_w     = cursor_r >= bits_total;
  assign bit_w      = rd_byte_r[cursor_r[2:0]];
  assign mt         = code_match(acc_r, n_r);
  assign hit_w      = top_hit(mt.hit);
  assign lim_in     = ({1'b0, q_item.text_limit} > 15'(MAX_TEXT)) ? 15'(MAX_TEXT)
                                                                  : {1'b0, q_item.text_limit};
  assign limit_w    = TW'(lim_in);
  assign lim_hit_w  = (q_item.new_string ? TW'(0) : chars_r) >= limit_w;

  // byte fetch: registered read; the decoder waits on fetch_r after each cursor byte change
  always_ff @(posedge clk) begin
    rd_byte_r <= buf_mem[cursor_r[AW+2:3]];
    if (q_pop && q_item.req_type == REQ_APPEND && count_r < CW'(BUFFER_BYTES))
      buf_mem[count_r[AW-1:0]] <= q_item.data_byte;
  end

  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_valid;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_item.req_type == REQ_NUMBER) state_nxt = ST_RAW;
          else if (q_item.req_type == REQ_TEXT) begin
            if (lim_hit_w) state_nxt = ST_DONE;
            else state_nxt = ST_SYM;
          end
        end
      end
      ST_RAW: begin
        if (raw_left_r == 3'd0 || done_w) state_nxt = ST_SYM;
      end
      ST_SYM: begin
        if (cur_r.req_type == REQ_NUMBER && bytes_left_r == 3'd0) state_nxt = ST_DONE;
        else if (!fetch_r) begin
          if (!hit_w[8] || !mt.deeper || n_r >= 5'(MaxCodeLen) || done_w) begin
            if (hit_w[8] || cur_r.req_type == REQ_TEXT) state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid = state_r == ST_DONE;
    res.at_end = done_w;
    res.text_end = 1'b0;
    res.value = '0;
    if (cur_r.req_type == REQ_TEXT) begin
      res.value = tval_r;
      res.text_end = tend_r;
    end else if (fail_r) begin
      res.value = '1;
    end else begin
      res.value = raw_r | (dec_r << cur_r.width[2:0]);
      if (cur_r.signed_read && cur_r.width != 6'd0 && cur_r.width < 6'd32
          && res.value[cur_r.width[4:0] - 5'd1])
        res.value = res.value | ~((32'd1 << cur_r.width[4:0]) - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      chars_r  <= '0;
      fetch_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            cur_r        <= q_item;
            raw_left_r   <= q_item.width[2:0];
            raw_pos_r    <= '0;
            bytes_left_r <= q_item.width[5:3];
            byte_idx_r   <= '0;
            raw_r        <= '0;
            dec_r        <= '0;
            acc_r        <= '0;
            n_r          <= '0;
            fail_r       <= 1'b0;
            tend_r       <= (q_item.req_type == REQ_TEXT) && lim_hit_w;
            tval_r       <= '0;
            fetch_r      <= 1'b1;
            case (q_item.req_type)
              REQ_CLEAR: begin
                count_r  <= '0;
                cursor_r <= '0;
                chars_r  <= '0;
              end
              REQ_APPEND: begin
                if (count_r < CW'(BUFFER_BYTES)) count_r <= count_r + CW'(1);
              end
              REQ_TEXT: begin
                if (q_item.new_string) chars_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_RAW: begin
          if (raw_left_r != 3'd0 && !done_w) begin
            if (fetch_r) fetch_r <= 1'b0;
            else begin
              raw_r[raw_pos_r] <= bit_w;
              raw_pos_r  <= raw_pos_r + 3'd1;
              raw_left_r <= raw_left_r - 3'd1;
              cursor_r   <= cursor_r + BW'(1);
              fetch_r    <= cursor_r[2:0] == 3'd7;
            end
          end else fetch_r <= 1'b1;
        end
        ST_SYM: begin
          if (fetch_r) fetch_r <= 1'b0;
          else if (!(cur_r.req_type == REQ_NUMBER && bytes_left_r == 3'd0)) begin
            if (!hit_w[8]) begin
              // symbol found
              acc_r <= '0;
              n_r   <= '0;
              if (cur_r.req_type == REQ_NUMBER) begin
                dec_r[byte_idx_r*8 +: 8] <= hit_w[7:0];
                byte_idx_r   <= byte_idx_r + 2'd1;
                bytes_left_r <= bytes_left_r - 3'd1;
              end else if (hit_w[7:0] == 8'd0) begin
                tend_r <= 1'b1;
              end else if (cur_r.nl_stop && hit_w[7:0] == ByteNewline) begin
                tend_r <= 1'b1;
                tval_r <= 32'(ByteNewline);
              end else begin
                tval_r <= (hit_w[7] || hit_w[7:0] == BytePercent) ? 32'(ByteDot)
                                                                  : 32'(hit_w[7:0]);
                chars_r <= chars_r + TW'(1);
              end
            end else if (!mt.deeper || n_r >= 5'(MaxCodeLen) || done_w) begin
              fail_r <= 1'b1;
              tend_r <= 1'b1;
              tval_r <= '1;
            end else begin
              acc_r[n_r[3:0]] <= bit_w;
              n_r      <= n_r + 5'd1;
              cursor_r <= cursor_r + BW'(1);
              fetch_r  <= cursor_r[2:0] == 3'd7;
            end
          end
        end
        default: fetch_r <= 1'b1;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_valid |=> !res_valid)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(BUFFER_BYTES))
    else $error("byte count beyond buffer");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_SYM) |-> n_r <= 5'(MaxCodeLen))
    else $error("code length overrun");

endmodule

@@ sv/static_huffman_bit_reader.sv @@
// a number read first takes the raw low bits of the width, then decodes one code per
// whole byte of the width; a text read decodes one code, or goes straight to the
// result when the char limit is reached. clear and append are handled while idle
// throughput: one item at a time in the decoder, a two-entry queue takes items ahead
// reset clears byte count, cursor and char count; results last one cycle, no stall
module static_huffman_bit_reader
  import shbr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16384,
  parameter int MAX_TEXT     = 8192
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic     q_full, q_push, q_valid, q_pop, take;
  in_item_t q_in, q_head;

  assign busy = q_full;

  shbr_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .q_full(q_full), .take(take), .q_push(q_push), .q_item(q_in)
  );

  shbr_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in),
    .pop(q_pop), .full(q_full), .valid(q_valid), .head(q_head)
  );

  shbr_back #(.BUFFER_BYTES(BUFFER_BYTES), .MAX_TEXT(MAX_TEXT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_head),
    .q_pop(q_pop), .res_valid(out_valid), .res(out_item)
  );

  assert property (@(posedge clk) disable iff (!rst_n) take |-> !busy)
    else $error("transfer while busy");

endmodule
